// ----- design/jbec_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jbec_pkg: shared types, constants and code tables
// Holds the coefficient width, the Huffman code tables built from the
// standard baseline bit counts and symbol lists, and the packer request type.
// ============================================================================
package jbec_pkg;

    // Width of one quantized coefficient on the input stream.
    localparam int COEF_BITS = 12;
    localparam int S_TDATA_W = ((COEF_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = 3;

    // The DC difference needs one bit more than a coefficient, and at least
    // enough to compare against the baseline limit.
    localparam int DIFF_W = (COEF_BITS >= 12) ? COEF_BITS + 1 : 13;
    // Saturated values always fit in 12 bits (category 11 at most).
    localparam int VAL_W  = 12;
    localparam int MAG_W  = VAL_W - 1;

    localparam int DC_LIMIT = 2047;
    localparam int AC_LIMIT = 1023;

    localparam logic       OP_CODE    = 1'b0;
    localparam logic       OP_FLUSH   = 1'b1;
    localparam logic [1:0] COMP_LUMA  = 2'd0;
    localparam logic [1:0] COMP_CR    = 2'd2;
    localparam logic [1:0] COMP_UNDEF = 2'd3;

    localparam logic [7:0] SYM_ZRL    = 8'hF0;
    localparam logic [7:0] SYM_EOB    = 8'h00;
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;
    localparam logic [6:0] PEND_MASK  = 7'h7F;
    localparam logic [5:0] RUN_LIMIT  = 6'd15;
    localparam logic [5:0] ZRL_RUN    = 6'd16;
    localparam logic [5:0] LAST_POS   = 6'd63;

    // One Huffman table entry: code length and right-aligned code.
    typedef struct packed {
        logic [4:0]  len;
        logic [15:0] code;
    } hent_t;

    typedef hent_t [255:0] htab_t;

    // One put request to the bit packer. A pad request fills the partial
    // byte with ones; done marks the last request of an input item.
    typedef struct packed {
        logic [15:0] value;
        logic [4:0]  len;
        logic        pad;
        logic        done;
    } jbec_req_t;

    // Canonical code assignment, evaluated at elaboration. The first list
    // entry sits in the highest byte of each vector.
    function automatic htab_t build_tab(input logic [127:0] bits,
                                        input logic [1295:0] vals,
                                        input int nvals);
        htab_t t;
        int    code;
        int    pos;
        int    k;
        int    j;
        t    = '0;
        code = 0;
        pos  = 0;
        for (k = 0; k < 16; k++) begin
            for (j = 0; j < int'(bits[(15 - k) * 8 +: 8]) && pos < nvals; j++) begin
                t[vals[(nvals - 1 - pos) * 8 +: 8]].len  = 5'(k + 1);
                t[vals[(nvals - 1 - pos) * 8 +: 8]].code = 16'(code);
                pos++;
                code++;
            end
            code = code << 1;
        end
        return t;
    endfunction

    localparam logic [1295:0] VALS_DC = 1296'({
        8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11});

    localparam logic [1295:0] VALS_AC_L = {
        128'h01020300_04110512_21314106_13516107,
        128'h22711432_8191a108_2342b1c1_1552d1f0,
        128'h24336272_82090a16_1718191a_25262728,
        128'h292a3435_36373839_3a434445_46474849,
        128'h4a535455_56575859_5a636465_66676869,
        128'h6a737475_76777879_7a838485_86878889,
        128'h8a929394_95969798_999aa2a3_a4a5a6a7,
        128'ha8a9aab2_b3b4b5b6_b7b8b9ba_c2c3c4c5,
        128'hc6c7c8c9_cad2d3d4_d5d6d7d8_d9dae1e2,
        128'he3e4e5e6_e7e8e9ea_f1f2f3f4_f5f6f7f8,
        16'hf9fa};

    localparam logic [1295:0] VALS_AC_C = {
        128'h00010203_11040521_31061241_51076171,
        128'h13223281_08144291_a1b1c109_233352f0,
        128'h156272d1_0a162434_e125f117_18191a26,
        128'h2728292a_35363738_393a4344_45464748,
        128'h494a5354_55565758_595a6364_65666768,
        128'h696a7374_75767778_797a8283_84858687,
        128'h88898a92_93949596_9798999a_a2a3a4a5,
        128'ha6a7a8a9_aab2b3b4_b5b6b7b8_b9bac2c3,
        128'hc4c5c6c7_c8c9cad2_d3d4d5d6_d7d8d9da,
        128'he2e3e4e5_e6e7e8e9_eaf2f3f4_f5f6f7f8,
        16'hf9fa};

    localparam htab_t TAB_DC_L = build_tab(128'h00010501_01010101_01000000_00000000,
                                           VALS_DC, 12);
    localparam htab_t TAB_DC_C = build_tab(128'h00030101_01010101_01010100_00000000,
                                           VALS_DC, 12);
    localparam htab_t TAB_AC_L = build_tab(128'h00020103_03020403_05050404_0000017d,
                                           VALS_AC_L, 162);
    localparam htab_t TAB_AC_C = build_tab(128'h00020102_04040304_07050404_00010277,
                                           VALS_AC_C, 162);

    function automatic hent_t code_lookup(input logic chroma, input logic ac,
                                          input logic [7:0] sym);
        hent_t e;
        case ({ac, chroma})
            2'b00:   e = TAB_DC_L[sym];
            2'b01:   e = TAB_DC_C[sym];
            2'b10:   e = TAB_AC_L[sym];
            default: e = TAB_AC_C[sym];
        endcase
        return e;
    endfunction

endpackage

// ----- design/jbec_coder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jbec_coder: coefficient sequencer
// Tracks block position, zero run and DC predictors, and turns each input
// item into a short series of put requests for the shared bit packer.
// ============================================================================
module jbec_coder import jbec_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_op,
    input  logic [1:0]                  in_comp,
    input  logic signed [COEF_BITS-1:0] in_coef,
    output logic                        req_valid,
    input  logic                        req_ready,
    output jbec_req_t                   req
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_CAT  = 3'd2;
    localparam logic [2:0] S_ZRL  = 3'd3;
    localparam logic [2:0] S_CODE = 3'd4;
    localparam logic [2:0] S_MAG  = 3'd5;
    localparam logic [2:0] S_TAIL = 3'd6;
    localparam logic [2:0] S_PAD  = 3'd7;

    logic [2:0]                  state_reg, state_next;
    logic                        op_reg, op_next;
    logic [1:0]                  comp_reg, comp_next;
    logic signed [COEF_BITS-1:0] coef_reg, coef_next;
    logic signed [COEF_BITS-1:0] pred_reg [3];
    logic signed [COEF_BITS-1:0] pred_next [3];
    logic [5:0]                  run_reg, run_next;
    logic [5:0]                  pos_reg, pos_next;
    logic signed [VAL_W-1:0]     val_reg, val_next;
    logic [3:0]                  cat_reg, cat_next;
    logic [MAG_W-1:0]            mag_reg, mag_next;
    logic                        dc_reg, dc_next;
    logic                        eob_reg, eob_next;

    logic signed [DIFF_W-1:0] coef_ext;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] sat;
    logic signed [VAL_W-1:0]  val_abs;
    logic                     chroma;
    hent_t                    ent;
    hent_t                    zrl_ent;
    hent_t                    eob_ent;

    function automatic logic [3:0] category(input logic [MAG_W-1:0] m);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) begin
                c = 4'(i + 1);
            end
        end
        return c;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign chroma   = (comp_reg != COMP_LUMA);
    assign coef_ext = DIFF_W'(coef_reg);
    assign diff     = coef_ext - DIFF_W'(pred_reg[comp_reg]);
    assign val_abs  = (val_reg < 0) ? -val_reg : val_reg;
    assign ent      = code_lookup(chroma, !dc_reg,
                                  dc_reg ? {4'd0, cat_reg} : {run_reg[3:0], cat_reg});
    assign zrl_ent  = code_lookup(chroma, 1'b1, SYM_ZRL);
    assign eob_ent  = code_lookup(chroma, 1'b1, SYM_EOB);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        comp_next  = comp_reg;
        coef_next  = coef_reg;
        pred_next  = pred_reg;
        run_next   = run_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        cat_next   = cat_reg;
        mag_next   = mag_reg;
        dc_next    = dc_reg;
        eob_next   = eob_reg;
        sat        = '0;
        req_valid  = 1'b0;
        req        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    comp_next  = (in_comp == COMP_UNDEF) ? COMP_CR : in_comp;
                    coef_next  = in_coef;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (op_reg == OP_FLUSH) begin
                    state_next = S_PAD;
                end else begin
                    pos_next = pos_reg + 6'd1;
                    if (pos_reg == '0) begin
                        // DC: difference from this component's predictor.
                        sat = diff;
                        if (diff > DIFF_W'(DC_LIMIT)) begin
                            sat = DIFF_W'(DC_LIMIT);
                        end else if (diff < -DIFF_W'(DC_LIMIT)) begin
                            sat = -DIFF_W'(DC_LIMIT);
                        end
                        pred_next[comp_reg] = coef_reg;
                        val_next   = VAL_W'(sat);
                        run_next   = '0;
                        dc_next    = 1'b1;
                        state_next = S_CAT;
                    end else if (coef_reg == '0) begin
                        run_next   = (pos_reg == LAST_POS) ? 6'd0 : run_reg + 6'd1;
                        eob_next   = (pos_reg == LAST_POS);
                        dc_next    = 1'b0;
                        state_next = S_TAIL;
                    end else begin
                        sat = coef_ext;
                        if (coef_ext > DIFF_W'(AC_LIMIT)) begin
                            sat = DIFF_W'(AC_LIMIT);
                        end else if (coef_ext < -DIFF_W'(AC_LIMIT)) begin
                            sat = -DIFF_W'(AC_LIMIT);
                        end
                        val_next   = VAL_W'(sat);
                        dc_next    = 1'b0;
                        state_next = S_CAT;
                    end
                end
            end
            S_CAT: begin
                cat_next = category(val_abs[MAG_W-1:0]);
                // Negative values send the low bits of value minus one.
                mag_next = (val_reg < 0) ? MAG_W'(val_reg - VAL_W'(1)) : val_reg[MAG_W-1:0];
                state_next = dc_reg ? S_CODE : S_ZRL;
            end
            S_ZRL: begin
                if (run_reg > RUN_LIMIT) begin
                    req_valid  = 1'b1;
                    req.value  = zrl_ent.code;
                    req.len    = zrl_ent.len;
                    if (req_ready) begin
                        run_next = run_reg - ZRL_RUN;
                    end
                end else begin
                    state_next = S_CODE;
                end
            end
            S_CODE: begin
                req_valid = 1'b1;
                req.value = ent.code;
                req.len   = ent.len;
                if (req_ready) begin
                    run_next   = '0;
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                req_valid = 1'b1;
                req.value = 16'(mag_reg);
                req.len   = 5'(cat_reg);
                req.done  = 1'b1;
                if (req_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_TAIL: begin
                // End of block sends EOB; any other zero only closes the item.
                req_valid = 1'b1;
                req.done  = 1'b1;
                if (eob_reg) begin
                    req.value = eob_ent.code;
                    req.len   = eob_ent.len;
                end
                if (req_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_PAD: begin
                req_valid = 1'b1;
                req.pad   = 1'b1;
                req.done  = 1'b1;
                if (req_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            run_reg   <= '0;
            pos_reg   <= '0;
            pred_reg  <= '{default: '0};
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            pos_reg   <= pos_next;
            pred_reg  <= pred_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        comp_reg <= comp_next;
        coef_reg <= coef_next;
        val_reg  <= val_next;
        cat_reg  <= cat_next;
        mag_reg  <= mag_next;
        dc_reg   <= dc_next;
        eob_reg  <= eob_next;
    end

endmodule

// ----- design/jbec_packer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jbec_packer: shared bit packer and byte emitter
// Shifts each code into the pending bits, drains whole bytes one per cycle
// while not stalled, stuffing a zero after 0xFF, into the output register.
// ============================================================================
module jbec_packer import jbec_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    output logic      req_ready,
    input  jbec_req_t req,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,
    output logic      m_tlast
);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_DRAIN = 2'd1;
    localparam logic [1:0] P_STUFF = 2'd2;
    localparam logic [1:0] P_LAST  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [22:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [7:0]  hold_reg, hold_next;
    logic        hold_vld_reg, hold_vld_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        ovld_reg, ovld_next;

    logic [4:0]  put_len;
    logic [15:0] put_val;
    logic [15:0] put_mask;
    logic [6:0]  pend;
    logic [7:0]  drain_byte;
    logic [7:0]  push_byte;
    logic        out_free;
    logic        can_push;
    logic        push;
    logic        emit_last;
    logic [1:0]  end_state;

    assign req_ready = (state_reg == P_IDLE);
    assign m_tvalid  = ovld_reg;
    assign m_tdata   = obyte_reg;
    assign m_tlast   = olast_reg;

    assign out_free  = !ovld_reg || m_tready;
    assign can_push  = !hold_vld_reg || out_free;
    assign end_state = done_reg ? P_LAST : P_IDLE;

    // A pad request tops the partial byte up to eight bits with ones.
    assign put_len  = req.pad ? ((cnt_reg[2:0] == 3'd0) ? 5'd0 : 5'd8 - {2'b00, cnt_reg[2:0]})
                              : req.len;
    assign put_val  = req.pad ? 16'hFFFF : req.value;
    assign put_mask = 16'((17'd1 << put_len) - 17'd1);
    assign pend     = acc_reg[6:0] & PEND_MASK & 7'((8'd1 << cnt_reg[2:0]) - 8'd1);
    assign drain_byte = 8'(acc_reg >> (cnt_reg - 5'd8));

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        done_next     = done_reg;
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        ovld_next     = ovld_reg && !m_tready;
        push          = 1'b0;
        push_byte     = drain_byte;
        emit_last     = 1'b0;

        unique case (state_reg)
            P_IDLE: begin
                if (req_valid) begin
                    acc_next   = (23'(pend) << put_len) | 23'(put_val & put_mask);
                    cnt_next   = cnt_reg + put_len;
                    done_next  = req.done;
                    state_next = P_DRAIN;
                end
            end
            P_DRAIN: begin
                if (cnt_reg < 5'd8) begin
                    state_next = end_state;
                end else if (can_push) begin
                    push     = 1'b1;
                    cnt_next = cnt_reg - 5'd8;
                    if (drain_byte == BYTE_FF) begin
                        state_next = P_STUFF;
                    end else if (cnt_reg < 5'd16) begin
                        state_next = end_state;
                    end
                end
            end
            P_STUFF: begin
                if (can_push) begin
                    push       = 1'b1;
                    push_byte  = BYTE_STUFF;
                    state_next = (cnt_reg < 5'd8) ? end_state : P_DRAIN;
                end
            end
            P_LAST: begin
                if (!hold_vld_reg) begin
                    state_next = P_IDLE;
                end else if (out_free) begin
                    emit_last  = 1'b1;
                    state_next = P_IDLE;
                end
            end
            default: begin
                state_next = P_IDLE;
            end
        endcase

        // The newest byte waits in the hold stage until it is known whether
        // another byte of the same item follows it.
        if (push) begin
            if (hold_vld_reg) begin
                obyte_next = hold_reg;
                olast_next = 1'b0;
                ovld_next  = 1'b1;
            end
            hold_next     = push_byte;
            hold_vld_next = 1'b1;
        end
        if (emit_last) begin
            obyte_next    = hold_reg;
            olast_next    = 1'b1;
            ovld_next     = 1'b1;
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= P_IDLE;
            cnt_reg      <= '0;
            hold_vld_reg <= 1'b0;
            ovld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hold_vld_reg <= hold_vld_next;
            ovld_reg     <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        done_reg  <= done_next;
        hold_reg  <= hold_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

// ----- design/jpeg_baseline_entropy_coder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jpeg_baseline_entropy_coder: baseline JPEG Huffman entropy coder
// Codes zigzag-ordered quantized coefficients with the standard baseline
// tables and emits the packed, byte-stuffed entropy-coded stream.
// ============================================================================
// Usage. The slave stream carries one item per transfer: s_tuser[0] is the
// operation (code one coefficient, or flush) and s_tuser[2:1] the component
// (luma, Cb, Cr; the unused code is taken as Cr). s_tdata holds the signed
// coefficient. The first coefficient of every 64 is the DC term of a block.
// The master stream carries one stream byte per transfer, stuffed zeros
// included, and m_tlast marks the final byte caused by an input item. Items
// that produce no byte cause no master transfer at all.
// An item is taken only when the coder is idle, so s_tready drops until the
// coder has handed the item's last code to the packer. A zero AC coefficient
// or a flush sends one request, a DC coefficient its code and magnitude
// bits, and a nonzero AC coefficient a sixteen-zero run code per run of
// sixteen zeros before it, then its code and magnitude bits. When a code
// completes more than one byte, or a 0xFF needs its stuffed zero, the packer
// holds the next code back until every such byte is pushed. The final byte of
// an item leaves the hold stage for the output register in the last state.
// Reset clears the pending bits, the block position, zero run and the three
// DC predictors. When the receiver stalls, one byte waits in the output
// register and one more in the hold stage; then the packer stops and the
// coder takes at most one further item before s_tready stays low until
// m_tready returns.
// ============================================================================
module jpeg_baseline_entropy_coder import jbec_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [COEF_BITS-1:0] coefficient, rest zero
    input  logic [S_TUSER_W-1:0] s_tuser,   // [0] op, [2:1] component
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast
);

    // Handshake between the sequencer and the shared bit packer.
    logic      req_valid;
    logic      req_ready;
    jbec_req_t req;

    // The sequencer owns all per-block state and decides which codes an
    // item needs; it hands them one at a time to the packer.
    jbec_coder u_coder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_comp   (s_tuser[2:1]),
        .in_coef   ($signed(s_tdata[COEF_BITS-1:0])),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // The packer shifts each code into the pending bits and drains whole
    // bytes, stuffing a zero after every 0xFF, into the output register.
    jbec_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- design/jbec_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// jbec_checker: port-level checks for the entropy coder
// Watches the top-level streams and flags protocol and stuffing violations.
// ============================================================================
module jbec_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output byte keeps its value and its last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transfer changed");

    // No output transfer is offered right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid directly after reset");

    // A 0xFF byte is never the last of an item; its stuffed zero follows it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == 8'hFF |-> !m_tlast)
        else $error("0xFF byte marked as the last of an item");

    // Each item keeps the coder busy, so no transfer follows directly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

endmodule

bind jpeg_baseline_entropy_coder jbec_checker u_checker (.*);
